// ===== sv/assert_macros.svh =====
// Assertion macros included by the slotted page space manager unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: label");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== sv/spsm_pkg.sv =====
// Package for the slotted page space manager: sizes, opcodes and status codes.
package spsm_pkg;
   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int SLOT_BYTES_DEF   = 8;
   localparam int MAX_SLOTS_DEF    = 64;
   localparam int LEN_W  = 13;
   localparam int SLOT_W = 6;
   localparam int PAGE_W = 32;

   typedef enum logic [1:0] {
      OP_GET = 2'd0, OP_INSERT = 2'd1, OP_DELETE = 2'd2, OP_UPDATE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NO_SPACE = 2'd1, ST_NOT_FOUND = 2'd2, ST_RSVD = 2'd3
   } status_type;
endpackage

// ===== sv/slotted_page_space_manager_unit.sv =====
// Slotted page space manager: slot directory sequencer over one directory RAM.
// One request is handled at a time. A get reads the slot's entry and answers.
// Insert scans the directory for the lowest deleted slot, one entry at a time
// (up to total_ff entries); delete and a moving update walk every directory
// entry to shift offsets, also one entry at a time through the directory RAM.
// The unit returns to idle before the next request can be accepted.
// A finished response sits in an output register; the next request is taken
// while it waits, and its own response waits for that register to drain.
`include "assert_macros.svh"
module slotted_page_space_manager_unit #(
   parameter int PAGE_BYTES   = spsm_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES = spsm_pkg::HEADER_BYTES_DEF,
   parameter int SLOT_BYTES   = spsm_pkg::SLOT_BYTES_DEF,
   parameter int MAX_SLOTS    = spsm_pkg::MAX_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0], req_slot[7:2], req_key_bytes[20:8], req_data_bytes[33:21], zeros
   input  logic [39:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], out_slot[7:2], record_page[39:8], write_offset[52:40],
   // out_key_bytes[65:53], out_data_bytes[78:66], move_valid[79],
   // move_source[92:80], move_dest[105:93], move_bytes[118:106], zeros
   output logic [119:0] rsp_tdata
);
   import spsm_pkg::*;

   localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW  = $clog2(MAX_SLOTS + 1);
   localparam int EW  = 2 * LEN_W + 1 + LEN_W; // deleted, data, key, offset
   localparam int SW  = LEN_W + 6;             // wide enough for space math

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_RDW, S_DECIDE, S_SCAN, S_SCANW,
      S_FIX_RD, S_FIX_WR, S_WRITE, S_DONE
   } state_type;

   state_type        state_ff;
   logic [1:0]       op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [LEN_W-1:0] kb_ff, db_ff;
   logic [31:0]      page_ff;
   logic [CW-1:0]    total_ff;
   logic [LEN_W-1:0] fend_ff;
   logic [AW-1:0]    idx_ff;
   logic [CW-1:0]    cnt_ff;
   logic [LEN_W-1:0] ofs_ff, cur_k_ff, cur_d_ff, shift_ff;
   logic             rsp_v_ff;
   logic [119:0]     rsp_d_ff;

   // final entry write for the target slot
   logic [EW-1:0]    wr_ent_ff;

   logic             ram_we;
   logic [AW-1:0]    ram_wa, ram_ra;
   logic [EW-1:0]    ram_wd, ram_rd;

   spsm_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_dir (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   logic [LEN_W-1:0] e_ofs, e_key, e_dat;
   logic             e_del;
   assign e_ofs = ram_rd[LEN_W-1:0];
   assign e_key = ram_rd[2*LEN_W-1:LEN_W];
   assign e_dat = ram_rd[3*LEN_W-1:2*LEN_W];
   assign e_del = ram_rd[EW-1];

   logic [SW-1:0] dir_end, space, req_sum, cur_sum;
   assign dir_end = SW'(HEADER_BYTES) + SW'(total_ff) * SW'(SLOT_BYTES);
   assign space   = (dir_end > SW'(fend_ff)) ? '0 : SW'(fend_ff) - dir_end;
   assign req_sum = SW'(kb_ff) + SW'(db_ff);
   assign cur_sum = SW'(cur_k_ff) + SW'(cur_d_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   always_comb begin
      ram_ra = slot_ff[AW-1:0];
      case (state_ff)
         S_SCAN, S_FIX_RD: ram_ra = idx_ff;
         default: ram_ra = slot_ff[AW-1:0];
      endcase
      ram_we = 1'b0;
      ram_wa = idx_ff;
      ram_wd = ram_rd;
      if (state_ff == S_FIX_WR && e_ofs < ofs_ff && idx_ff != slot_ff[AW-1:0]) begin
         ram_we = 1'b1;
         ram_wd = {e_del, e_dat, e_key, e_ofs + shift_ff};
      end else if (state_ff == S_WRITE) begin
         ram_we = 1'b1;
         ram_wa = slot_ff[AW-1:0];
         ram_wd = wr_ent_ff;
      end
   end

   // response fields assembled into rsp_d_ff
   logic [1:0]       o_st;
   logic [LEN_W-1:0] o_wo, o_k, o_d, o_ms, o_md, o_mb;
   logic             o_mv;
   logic [31:0]      o_pg;
   logic [SLOT_W-1:0] o_sl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
         total_ff <= '0;
         fend_ff  <= LEN_W'(PAGE_BYTES);
         page_ff  <= '0;
      end else begin
         if (csr_wr_en) page_ff <= csr_wr_data;
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               op_ff   <= req_tdata[1:0];
               slot_ff <= req_tdata[7:2];
               kb_ff   <= req_tdata[20:8];
               db_ff   <= req_tdata[33:21];
               o_st <= ST_OK; o_sl <= req_tdata[7:2]; o_pg <= '0; o_wo <= '0;
               o_k <= '0; o_d <= '0; o_mv <= 1'b0; o_ms <= '0; o_md <= '0; o_mb <= '0;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_RDW;
            S_RDW: begin
               ofs_ff <= e_ofs; cur_k_ff <= e_key; cur_d_ff <= e_dat;
               if (op_ff == OP_INSERT) begin
                  idx_ff <= '0; cnt_ff <= '0;
                  state_ff <= (total_ff == '0) ? S_DECIDE : S_SCAN;
                  o_sl <= '0;
               end else if (CW'(slot_ff) >= total_ff || e_del) begin
                  o_st <= ST_NOT_FOUND;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DECIDE;
               end
            end
            S_SCAN: state_ff <= S_SCANW;
            S_SCANW: begin
               if (e_del) begin
                  state_ff <= S_DECIDE; // idx_ff points at reusable slot
               end else if (cnt_ff + 1'b1 == total_ff) begin
                  cnt_ff <= total_ff;
                  state_ff <= S_DECIDE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_DECIDE: begin
               state_ff <= S_DONE;
               case (op_ff)
                  OP_GET: begin
                     o_pg <= page_ff; o_wo <= ofs_ff; o_k <= cur_k_ff; o_d <= cur_d_ff;
                  end
                  OP_INSERT: begin
                     if (req_sum > space || (cnt_ff == total_ff &&
                         (total_ff >= CW'(MAX_SLOTS) ||
                          req_sum + SW'(SLOT_BYTES) > space))) begin
                        o_st <= ST_NO_SPACE;
                     end else begin
                        if (cnt_ff == total_ff) begin
                           total_ff <= total_ff + 1'b1;
                           slot_ff  <= SLOT_W'(total_ff);
                           o_sl     <= SLOT_W'(total_ff);
                        end else begin
                           slot_ff <= SLOT_W'(idx_ff);
                           o_sl    <= SLOT_W'(idx_ff);
                        end
                        fend_ff <= fend_ff - req_sum[LEN_W-1:0];
                        wr_ent_ff <= {1'b0, db_ff, kb_ff, fend_ff - req_sum[LEN_W-1:0]};
                        o_wo <= fend_ff - req_sum[LEN_W-1:0];
                        o_k <= kb_ff; o_d <= db_ff;
                        state_ff <= S_WRITE;
                     end
                  end
                  OP_DELETE: begin
                     o_k <= cur_k_ff; o_d <= cur_d_ff;
                     shift_ff <= cur_sum[LEN_W-1:0];
                     fend_ff <= fend_ff + cur_sum[LEN_W-1:0];
                     wr_ent_ff <= {1'b1, cur_d_ff, cur_k_ff, ofs_ff};
                     if (ofs_ff != fend_ff) begin
                        o_mv <= 1'b1; o_ms <= fend_ff;
                        o_md <= fend_ff + cur_sum[LEN_W-1:0];
                        o_mb <= ofs_ff - fend_ff;
                     end
                     idx_ff <= '0; cnt_ff <= '0;
                     state_ff <= (ofs_ff != fend_ff && total_ff != '0) ? S_FIX_RD : S_WRITE;
                  end
                  default: begin // update
                     idx_ff <= '0; cnt_ff <= '0;
                     if (req_sum == cur_sum) begin
                        o_wo <= ofs_ff; o_k <= kb_ff; o_d <= db_ff;
                        wr_ent_ff <= {1'b0, db_ff, kb_ff, ofs_ff};
                        state_ff <= S_WRITE;
                     end else if (req_sum < cur_sum) begin
                        shift_ff <= cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0];
                        fend_ff <= fend_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0];
                        o_wo <= ofs_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0];
                        wr_ent_ff <= {1'b0, db_ff, kb_ff,
                                      ofs_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0]};
                        o_k <= kb_ff; o_d <= db_ff;
                        if (ofs_ff > fend_ff) begin
                           o_mv <= 1'b1; o_ms <= fend_ff;
                           o_md <= fend_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0];
                           o_mb <= ofs_ff - fend_ff;
                           state_ff <= S_FIX_RD;
                        end else begin
                           state_ff <= S_WRITE;
                        end
                     end else if (req_sum - cur_sum > space) begin
                        o_st <= ST_NO_SPACE;
                     end else begin
                        // grow: remove then re-place at the low end
                        shift_ff <= cur_sum[LEN_W-1:0];
                        fend_ff <= fend_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0];
                        o_wo <= fend_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0];
                        wr_ent_ff <= {1'b0, db_ff, kb_ff,
                                      fend_ff + cur_sum[LEN_W-1:0] - req_sum[LEN_W-1:0]};
                        o_k <= kb_ff; o_d <= db_ff;
                        if (ofs_ff != fend_ff) begin
                           o_mv <= 1'b1; o_ms <= fend_ff;
                           o_md <= fend_ff + cur_sum[LEN_W-1:0];
                           o_mb <= ofs_ff - fend_ff;
                           state_ff <= S_FIX_RD;
                        end else begin
                           state_ff <= S_WRITE;
                        end
                     end
                  end
               endcase
            end
            // read data for idx_ff is valid in S_FIX_WR
            S_FIX_RD: state_ff <= S_FIX_WR;
            S_FIX_WR: begin
               if (cnt_ff + 1'b1 >= total_ff) begin
                  state_ff <= S_WRITE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_FIX_RD;
               end
            end
            S_WRITE: state_ff <= S_DONE;
            S_DONE: if (!rsp_v_ff) begin
               rsp_v_ff <= 1'b1;
               rsp_d_ff <= {1'b0, o_mb, o_md, o_ms, o_mv, o_d, o_k, o_wo, o_pg, o_sl, o_st};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_no_accept_busy, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff == S_RD))
   `ASSERT_NEVER(a_total_bound, clock, reset, total_ff > CW'(MAX_SLOTS))
   `ASSERT_NEVER(a_status_code, clock, reset, rsp_v_ff && rsp_d_ff[1:0] == ST_RSVD)
   `ASSERT_IMPL(a_move_zero, clock, reset,
      (rsp_v_ff && !rsp_d_ff[79]) |-> (rsp_d_ff[118:80] == '0))
endmodule

// ===== sv/spsm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module spsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sim/slotted_page_space_manager_unit_test.sv =====
// Testbench for the slotted page space manager: directed and random requests checked live.
`timescale 1ns / 1ps
module slotted_page_space_manager_unit_test;
   import spsm_pkg::*;

   localparam int unsigned PAGE_LEN    = 4096;
   localparam int unsigned HDR_SIZE    = 16;
   localparam int unsigned ENTRY_SIZE  = 8;
   localparam int unsigned DIR_ENTRIES = 64;
   localparam int unsigned LEN_MASK    = 13'h1FFF;
   localparam int unsigned SETTLE_CYCLES = 160;
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   // packed MSB first so it lines up with rsp_tdata[118:0]
   typedef struct packed {
      logic [12:0] mv_bytes;
      logic [12:0] mv_dest;
      logic [12:0] mv_src;
      logic        mv;
      logic [12:0] data_b;
      logic [12:0] key_b;
      logic [12:0] wr_ofs;
      logic [31:0] page;
      logic [5:0]  slot;
      status_type  status;
   } page_rsp_t;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [39:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;

   // predictor state
   int unsigned dir_offset [DIR_ENTRIES];
   int unsigned dir_key    [DIR_ENTRIES];
   int unsigned dir_data   [DIR_ENTRIES];
   bit          dir_deleted[DIR_ENTRIES];
   int unsigned dir_count;
   int unsigned free_top;
   logic [31:0] page_id;

   page_rsp_t   pending_rsp[$];
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned idle_pct;

   slotted_page_space_manager_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned free_bytes();
      int unsigned start;
      start = HDR_SIZE + dir_count * ENTRY_SIZE;
      return (start > free_top) ? 0 : free_top - start;
   endfunction

   // take a payload out of the packed area and close the gap
   function automatic void drop_payload(int unsigned s, inout page_rsp_t r);
      int unsigned ofs, size;
      ofs  = dir_offset[s];
      size = dir_key[s] + dir_data[s];
      if (ofs != free_top) begin
         r.mv       = 1'b1;
         r.mv_src   = 13'(free_top);
         r.mv_dest  = 13'(free_top + size);
         r.mv_bytes = 13'(ofs - free_top);
         for (int i = 0; i < dir_count; i++)
            if (dir_offset[i] < ofs) dir_offset[i] = (dir_offset[i] + size) & LEN_MASK;
      end
      dir_deleted[s] = 1'b1;
      free_top = (free_top + size) & LEN_MASK;
   endfunction

   function automatic page_rsp_t page_predict(opcode_type op, int unsigned s,
                                              int unsigned kb, int unsigned db);
      page_rsp_t r;
      int unsigned need, fs, idx, cur, ofs, n;
      r = '0;
      r.slot = 6'(s);
      need = kb + db;
      if (op != OP_INSERT && (s >= dir_count || dir_deleted[s])) begin
         r.status = ST_NOT_FOUND;
      end else begin
         case (op)
            OP_GET: begin
               r.page   = page_id;
               r.wr_ofs = 13'(dir_offset[s]);
               r.key_b  = 13'(dir_key[s]);
               r.data_b = 13'(dir_data[s]);
            end
            OP_INSERT: begin
               fs = free_bytes();
               idx = dir_count;
               r.slot = '0;
               for (int i = dir_count - 1; i >= 0; i--)
                  if (dir_deleted[i]) idx = i;
               if (need > fs || (idx == dir_count &&
                   (dir_count >= DIR_ENTRIES || need + ENTRY_SIZE > fs))) begin
                  r.status = ST_NO_SPACE;
               end else begin
                  if (idx == dir_count) dir_count++;
                  free_top = (free_top - need) & LEN_MASK;
                  dir_offset[idx]  = free_top;
                  dir_key[idx]     = kb;
                  dir_data[idx]    = db;
                  dir_deleted[idx] = 1'b0;
                  r.slot   = 6'(idx);
                  r.wr_ofs = 13'(free_top);
                  r.key_b  = 13'(kb);
                  r.data_b = 13'(db);
               end
            end
            OP_DELETE: begin
               r.key_b  = 13'(dir_key[s]);
               r.data_b = 13'(dir_data[s]);
               drop_payload(s, r);
            end
            default: begin
               cur = dir_key[s] + dir_data[s];
               ofs = dir_offset[s];
               if (need == cur) begin
                  r.wr_ofs = 13'(ofs);
               end else if (need < cur) begin
                  n = cur - need;
                  if (ofs > free_top) begin
                     r.mv       = 1'b1;
                     r.mv_src   = 13'(free_top);
                     r.mv_dest  = 13'(free_top + n);
                     r.mv_bytes = 13'(ofs - free_top);
                     for (int i = 0; i < dir_count; i++)
                        if (dir_offset[i] < ofs)
                           dir_offset[i] = (dir_offset[i] + n) & LEN_MASK;
                  end
                  free_top = (free_top + n) & LEN_MASK;
                  dir_offset[s] = (ofs + n) & LEN_MASK;
                  r.wr_ofs = 13'(dir_offset[s]);
               end else if (need - cur > free_bytes()) begin
                  r.status = ST_NO_SPACE;
               end else begin
                  drop_payload(s, r);
                  free_top = (free_top - need) & LEN_MASK;
                  dir_offset[s]  = free_top;
                  dir_deleted[s] = 1'b0;
                  r.wr_ofs = 13'(free_top);
               end
               if (r.status == ST_OK) begin
                  dir_key[s]  = kb;
                  dir_data[s] = db;
                  r.key_b  = 13'(kb);
                  r.data_b = 13'(db);
               end
            end
         endcase
      end
      return r;
   endfunction

   // sender; called at a falling edge, returns at a falling edge
   task automatic send_request(opcode_type op, int unsigned s, int unsigned kb,
                               int unsigned db);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'b0, db[12:0], kb[12:0], s[5:0], op};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(page_predict(op, s, kb, db));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_page(logic [31:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      page_id     = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready = ($urandom_range(99, 0) >= idle_pct);

   always @(posedge clock) begin
      page_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = page_rsp_t'(rsp_tdata[118:0]);
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.page !== want.page || got.wr_ofs !== want.wr_ofs ||
                got.key_b !== want.key_b || got.data_b !== want.data_b ||
                got.mv !== want.mv || got.mv_src !== want.mv_src ||
                got.mv_dest !== want.mv_dest || got.mv_bytes !== want.mv_bytes ||
                rsp_tdata[119] !== 1'b0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic test_empty_page();
      send_request(OP_GET, 0, 0, 0);
      send_request(OP_DELETE, 5, 0, 0);
      send_request(OP_UPDATE, 63, 4096, 4096);
      send_request(OP_INSERT, 17, 4096, 0);
   endtask

   task automatic test_insert_get();
      send_request(OP_INSERT, 0, 100, 50);
      send_request(OP_INSERT, 42, 0, 0);
      send_request(OP_INSERT, 0, 1000, 2000);
      send_request(OP_GET, 0, 0, 0);
      send_request(OP_GET, 1, 0, 0);
      send_request(OP_GET, 2, 0, 0);
      send_request(OP_GET, 3, 0, 0);
   endtask

   task automatic test_update_paths();
      send_request(OP_UPDATE, 0, 60, 90);      // same size
      send_request(OP_UPDATE, 0, 10, 20);      // shrink, shifts the area
      send_request(OP_UPDATE, 2, 1500, 1600);  // grow, delete then re-place
      send_request(OP_UPDATE, 2, 4096, 4096);  // no room
      send_request(OP_UPDATE, 1, 1, 2);
   endtask

   task automatic test_delete_reuse();
      send_request(OP_DELETE, 0, 0, 0);
      send_request(OP_GET, 0, 0, 0);
      send_request(OP_DELETE, 0, 0, 0);
      send_request(OP_UPDATE, 0, 3, 3);
      send_request(OP_INSERT, 9, 5, 5);        // takes the freed slot
      send_request(OP_DELETE, 0, 0, 0);        // payload at the low end, no move
   endtask

   task automatic gen_length(output int unsigned kb, output int unsigned db);
      case ($urandom_range(9, 0))
         7, 8: begin
            kb = $urandom_range(4096, 0);
            db = $urandom_range(4096, 0);
         end
         9: begin
            kb = $urandom_range(1, 0) * 4096;
            db = $urandom_range(1, 0) * 4096;
         end
         default: begin
            kb = $urandom_range(40, 0);
            db = $urandom_range(40, 0);
         end
      endcase
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned pick, s, kb, db;
      opcode_type op;
      repeat (count) begin
         pick = $urandom_range(99, 0);
         op = (pick < 20) ? OP_GET : (pick < 60) ? OP_INSERT :
              (pick < 80) ? OP_DELETE : OP_UPDATE;
         if (dir_count != 0 && $urandom_range(9, 0) != 0)
            s = $urandom_range(dir_count - 1, 0);
         else
            s = $urandom_range(63, 0);
         gen_length(kb, db);
         send_request(op, s, kb, db);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idle_pct = 23;
      page_id = '0;
      dir_count = 0;
      free_top = PAGE_LEN;
      for (int i = 0; i < DIR_ENTRIES; i++) begin
         dir_offset[i] = 0;
         dir_key[i] = 0;
         dir_data[i] = 0;
         dir_deleted[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_page();
      set_page(32'hFFFF_FFFF);
      test_insert_get();
      test_update_paths();
      test_delete_reuse();
      set_page(32'h0000_0000);
      test_random_traffic(130);
      set_page($urandom());
      idle_pct = 0;                            // back-to-back stretch
      test_random_traffic(120);
      idle_pct = 23;
      set_page(32'h8000_0001);
      test_random_traffic(130);
      set_page(32'hFFFF_FFFF);
      test_random_traffic(120);

      drain();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
